// File: design/lobm_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and result codes of the limit order book matcher.
// Has no dependencies; every other design and bench file except lobm_ram imports it.
package lobm_pkg;

   localparam int TICK_LEVELS  = 1024;
   localparam int POOL_SLOTS   = 64;
   localparam int SYMBOL_COUNT = 16;
   localparam int MAX_FILLS    = 63;

   localparam int TICK_W      = $clog2(TICK_LEVELS);
   localparam int SLOT_W      = $clog2(POOL_SLOTS);
   localparam int LINK_W      = 7;
   localparam int CNT_W       = $clog2(POOL_SLOTS + 1);
   localparam int BOOK_W      = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LVL_ENTRIES = SYMBOL_COUNT * 2 * TICK_LEVELS;
   localparam int LVL_W       = $clog2(LVL_ENTRIES);
   localparam int QE_W        = 2 * LINK_W;
   localparam int CLR_N       = (LVL_ENTRIES > POOL_SLOTS) ? LVL_ENTRIES : POOL_SLOTS;
   localparam int CLR_W       = $clog2(CLR_N);
   localparam int FILL_W      = 6;

   localparam logic [LINK_W-1:0] NIL_SLOT = 7'd64;

   // result kinds
   localparam logic [1:0] KIND_FILL      = 2'd0;
   localparam logic [1:0] KIND_DONE      = 2'd1;
   localparam logic [1:0] KIND_BAD_TICK  = 2'd2;
   localparam logic [1:0] KIND_POOL_FULL = 2'd3;

   typedef struct packed {
      logic [31:0] order_ident;
      logic [31:0] order_quantity;
      logic [15:0] limit_tick;
      logic        order_side;
      logic [3:0]  symbol_index;
   } lobm_order_type;

   typedef struct packed {
      logic        top_ask_valid;
      logic [9:0]  top_ask_tick;
      logic        top_bid_valid;
      logic [9:0]  top_bid_tick;
      logic        aggressor;
      logic [9:0]  fill_tick;
      logic [31:0] fill_quantity;
      logic [31:0] seller_ident;
      logic [31:0] buyer_ident;
      logic [3:0]  fill_symbol;
      logic        run_last;
      logic [1:0]  result_kind;
   } lobm_result_type;

   // flat index of one price level queue
   function automatic logic [LVL_W-1:0] lvl_index(input logic [BOOK_W-1:0] b,
                                                  input logic s,
                                                  input logic [TICK_W-1:0] t);
      int v;
      v = (int'(b) * 2 + int'(s)) * TICK_LEVELS + int'(t);
      return LVL_W'(v);
   endfunction

   // tick as carried in the 10-bit result fields
   function automatic logic [9:0] tick_out(input logic [TICK_W-1:0] t);
      logic [31:0] w;
      w = 32'(t);
      return w[9:0];
   endfunction

endpackage

// File: design/lobm_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, one read port with registered read data.
// Depends on nothing.
module lobm_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lobm_engine.sv
`timescale 1ns / 1ps
// Matching sequencer: level queue memory, slot stores, free stack and best ticks.
// Depends on lobm_pkg and lobm_ram.
module lobm_engine
   import lobm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            order_valid,
   input  lobm_order_type  order,
   output logic            order_ready,
   input  logic            out_free,
   output logic            emit_valid,
   output lobm_result_type emit_data
);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_CHECK   = 5'd2;
   localparam logic [4:0] S_PUSH1   = 5'd3;
   localparam logic [4:0] S_PUSH2   = 5'd4;
   localparam logic [4:0] S_M0      = 5'd5;
   localparam logic [4:0] S_M1      = 5'd6;
   localparam logic [4:0] S_M2      = 5'd7;
   localparam logic [4:0] S_M3      = 5'd8;
   localparam logic [4:0] S_M4      = 5'd9;
   localparam logic [4:0] S_M5      = 5'd10;
   localparam logic [4:0] S_M6      = 5'd11;
   localparam logic [4:0] S_POPB    = 5'd12;
   localparam logic [4:0] S_SCANB_R = 5'd13;
   localparam logic [4:0] S_SCANB_C = 5'd14;
   localparam logic [4:0] S_POPA    = 5'd15;
   localparam logic [4:0] S_SCANA_R = 5'd16;
   localparam logic [4:0] S_SCANA_C = 5'd17;
   localparam logic [4:0] S_STATUS  = 5'd18;

   // control state
   logic [4:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [FILL_W-1:0] fills_ff, fills_in;
   logic             bid_v_ff [SYMBOL_COUNT];
   logic             bid_v_in [SYMBOL_COUNT];
   logic             ask_v_ff [SYMBOL_COUNT];
   logic             ask_v_in [SYMBOL_COUNT];
   // payload
   logic [TICK_W-1:0] bid_t_ff [SYMBOL_COUNT];
   logic [TICK_W-1:0] bid_t_in [SYMBOL_COUNT];
   logic [TICK_W-1:0] ask_t_ff [SYMBOL_COUNT];
   logic [TICK_W-1:0] ask_t_in [SYMBOL_COUNT];
   lobm_order_type    ord_ff, ord_in;
   logic [BOOK_W-1:0] bk_ff, bk_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [QE_W-1:0]   bent_ff, bent_in;
   logic [QE_W-1:0]   aent_ff, aent_in;
   logic [31:0]       bq_ff, bq_in;
   logic [31:0]       aq_ff, aq_in;
   logic [31:0]       bid_id_ff, bid_id_in;
   logic [LINK_W-1:0] blink_ff, blink_in;
   logic [LINK_W-1:0] alink_ff, alink_in;
   logic [TICK_W-1:0] scan_ff, scan_in;

   // memory ports
   logic              lvl_we;
   logic [LVL_W-1:0]  lvl_wa, lvl_ra;
   logic [QE_W-1:0]   lvl_wd, lvl_rd;
   logic              stk_we;
   logic [SLOT_W-1:0] stk_wa, stk_ra, stk_wd, stk_rd;
   logic              id_we, qt_we, lk_we;
   logic [SLOT_W-1:0] id_wa, qt_wa, lk_wa, sl_ra;
   logic [31:0]       id_wd, qt_wd, id_rd, qt_rd;
   logic [LINK_W-1:0] lk_wd, lk_rd;

   logic [CNT_W-1:0]  cnt_dec;
   logic [TICK_W-1:0] push_tick;
   logic [LINK_W-1:0] bhead, ahead;
   logic [31:0]       tq;
   logic [LINK_W-1:0] lvl_head;

   lobm_ram #(.DEPTH(LVL_ENTRIES), .WIDTH(QE_W)) u_lvl (
      .clock(clock), .wr_en(lvl_we), .wr_addr(lvl_wa), .wr_data(lvl_wd),
      .rd_addr(lvl_ra), .rd_data(lvl_rd));
   lobm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(SLOT_W)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));
   lobm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(32)) u_ident (
      .clock(clock), .wr_en(id_we), .wr_addr(id_wa), .wr_data(id_wd),
      .rd_addr(sl_ra), .rd_data(id_rd));
   lobm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(32)) u_qty (
      .clock(clock), .wr_en(qt_we), .wr_addr(qt_wa), .wr_data(qt_wd),
      .rd_addr(sl_ra), .rd_data(qt_rd));
   lobm_ram #(.DEPTH(POOL_SLOTS), .WIDTH(LINK_W)) u_link (
      .clock(clock), .wr_en(lk_we), .wr_addr(lk_wa), .wr_data(lk_wd),
      .rd_addr(sl_ra), .rd_data(lk_rd));

   assign cnt_dec   = count_ff - CNT_W'(1);
   assign stk_ra    = cnt_dec[SLOT_W-1:0];
   assign push_tick = ord_ff.limit_tick[TICK_W-1:0];
   assign bhead     = bent_ff[QE_W-1:LINK_W];
   assign ahead     = aent_ff[QE_W-1:LINK_W];
   assign lvl_head  = lvl_rd[QE_W-1:LINK_W];
   assign tq        = (qt_rd < bq_ff) ? qt_rd : bq_ff;
   assign sl_ra     = (state_ff == S_M2) ? bhead[SLOT_W-1:0] : ahead[SLOT_W-1:0];
   assign order_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      count_in  = count_ff;
      fills_in  = fills_ff;
      bid_v_in  = bid_v_ff;
      ask_v_in  = ask_v_ff;
      bid_t_in  = bid_t_ff;
      ask_t_in  = ask_t_ff;
      ord_in    = ord_ff;
      bk_in     = bk_ff;
      slot_in   = slot_ff;
      bent_in   = bent_ff;
      aent_in   = aent_ff;
      bq_in     = bq_ff;
      aq_in     = aq_ff;
      bid_id_in = bid_id_ff;
      blink_in  = blink_ff;
      alink_in  = alink_ff;
      scan_in   = scan_ff;
      lvl_we = 1'b0; lvl_wa = '0; lvl_wd = {NIL_SLOT, NIL_SLOT}; lvl_ra = '0;
      stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
      id_we = 1'b0; id_wa = slot_ff; id_wd = ord_ff.order_ident;
      qt_we = 1'b0; qt_wa = slot_ff; qt_wd = ord_ff.order_quantity;
      lk_we = 1'b0; lk_wa = slot_ff; lk_wd = NIL_SLOT;
      emit_valid = 1'b0;
      emit_data  = '0;
      emit_data.fill_symbol = ord_ff.symbol_index;
      emit_data.aggressor   = ord_ff.order_side;
      emit_data.top_bid_valid = bid_v_ff[bk_ff];
      emit_data.top_bid_tick  = bid_v_ff[bk_ff] ? tick_out(bid_t_ff[bk_ff]) : 10'd0;
      emit_data.top_ask_valid = ask_v_ff[bk_ff];
      emit_data.top_ask_tick  = ask_v_ff[bk_ff] ? tick_out(ask_t_ff[bk_ff]) : 10'd0;
      emit_data.run_last = 1'b1;
      emit_data.result_kind = KIND_DONE;

      case (state_ff)
         // sweep the level memory to empty, reload the free stack
         S_CLEAR: begin
            lvl_we = (int'(clr_ff) < LVL_ENTRIES);
            lvl_wa = LVL_W'(clr_ff);
            if (int'(clr_ff) < POOL_SLOTS) begin
               stk_we = 1'b1;
               stk_wa = clr_ff[SLOT_W-1:0];
               stk_wd = SLOT_W'(POOL_SLOTS - 1) - clr_ff[SLOT_W-1:0];
            end
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_N - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (order_valid) begin
               ord_in   = order;
               bk_in    = BOOK_W'(order.symbol_index % SYMBOL_COUNT);
               fills_in = '0;
               state_in = S_CHECK;
            end
         end
         // reject or pop a free slot and fetch the level's queue ends
         S_CHECK: begin
            lvl_ra = lvl_index(bk_ff, ord_ff.order_side, push_tick);
            if ({1'b0, ord_ff.limit_tick} >= 17'(TICK_LEVELS)) begin
               emit_valid = 1'b1;
               emit_data.result_kind = KIND_BAD_TICK;
               if (out_free) state_in = S_IDLE;
            end else if (count_ff == '0 || int'(count_ff) > POOL_SLOTS) begin
               emit_valid = 1'b1;
               emit_data.result_kind = KIND_POOL_FULL;
               if (out_free) state_in = S_IDLE;
            end else begin
               count_in = cnt_dec;
               state_in = S_PUSH1;
            end
         end
         S_PUSH1: begin
            slot_in = stk_rd;
            bent_in = lvl_rd;
            id_we = 1'b1; id_wa = stk_rd;
            qt_we = 1'b1; qt_wa = stk_rd;
            lk_we = 1'b1; lk_wa = stk_rd; lk_wd = NIL_SLOT;
            state_in = S_PUSH2;
         end
         // append to the queue and move the best tick
         S_PUSH2: begin
            lvl_we = 1'b1;
            lvl_wa = lvl_index(bk_ff, ord_ff.order_side, push_tick);
            if (bhead == NIL_SLOT) begin
               lvl_wd = {LINK_W'(slot_ff), LINK_W'(slot_ff)};
            end else begin
               lvl_wd = {bhead, LINK_W'(slot_ff)};
               if (int'(bent_ff[LINK_W-1:0]) < POOL_SLOTS) begin
                  lk_we = 1'b1;
                  lk_wa = bent_ff[SLOT_W-1:0];
                  lk_wd = LINK_W'(slot_ff);
               end
            end
            if (!ord_ff.order_side) begin
               if (!bid_v_ff[bk_ff] || push_tick > bid_t_ff[bk_ff]) begin
                  bid_v_in[bk_ff] = 1'b1;
                  bid_t_in[bk_ff] = push_tick;
               end
            end else begin
               if (!ask_v_ff[bk_ff] || push_tick < ask_t_ff[bk_ff]) begin
                  ask_v_in[bk_ff] = 1'b1;
                  ask_t_in[bk_ff] = push_tick;
               end
            end
            state_in = S_M0;
         end
         // crossed book test
         S_M0: begin
            lvl_ra = lvl_index(bk_ff, 1'b0, bid_t_ff[bk_ff]);
            if (fills_ff == FILL_W'(MAX_FILLS) || !bid_v_ff[bk_ff] || !ask_v_ff[bk_ff]
                || bid_t_ff[bk_ff] < ask_t_ff[bk_ff]) begin
               state_in = S_STATUS;
            end else begin
               state_in = S_M1;
            end
         end
         S_M1: begin
            bent_in  = lvl_rd;
            lvl_ra   = lvl_index(bk_ff, 1'b1, ask_t_ff[bk_ff]);
            state_in = S_M2;
         end
         S_M2: begin
            aent_in = lvl_rd;
            if (int'(bhead) >= POOL_SLOTS || int'(lvl_head) >= POOL_SLOTS) begin
               state_in = S_STATUS;
            end else begin
               state_in = S_M3;
            end
         end
         S_M3: begin
            bq_in     = qt_rd;
            bid_id_in = id_rd;
            blink_in  = lk_rd;
            state_in  = S_M4;
         end
         // fill of front bid against front ask
         S_M4: begin
            emit_valid = 1'b1;
            emit_data.result_kind   = KIND_FILL;
            emit_data.run_last      = 1'b0;
            emit_data.buyer_ident   = bid_id_ff;
            emit_data.seller_ident  = id_rd;
            emit_data.fill_quantity = tq;
            emit_data.fill_tick     = tick_out(ask_t_ff[bk_ff]);
            emit_data.top_bid_valid = 1'b0;
            emit_data.top_bid_tick  = 10'd0;
            emit_data.top_ask_valid = 1'b0;
            emit_data.top_ask_tick  = 10'd0;
            if (out_free) begin
               fills_in = fills_ff + FILL_W'(1);
               bq_in    = bq_ff - tq;
               aq_in    = qt_rd - tq;
               alink_in = lk_rd;
               state_in = S_M5;
            end
         end
         S_M5: begin
            qt_we = 1'b1; qt_wa = bhead[SLOT_W-1:0]; qt_wd = bq_ff;
            state_in = S_M6;
         end
         S_M6: begin
            qt_we = 1'b1; qt_wa = ahead[SLOT_W-1:0]; qt_wd = aq_ff;
            if (bq_ff == '0) state_in = S_POPB;
            else if (aq_ff == '0) state_in = S_POPA;
            else state_in = S_M0;
         end
         // retire the front bid and free its slot
         S_POPB: begin
            lvl_we = 1'b1;
            lvl_wa = lvl_index(bk_ff, 1'b0, bid_t_ff[bk_ff]);
            lvl_wd = (blink_ff == NIL_SLOT) ? {NIL_SLOT, NIL_SLOT}
                                            : {blink_ff, bent_ff[LINK_W-1:0]};
            if (int'(count_ff) < POOL_SLOTS) begin
               stk_we   = 1'b1;
               stk_wa   = count_ff[SLOT_W-1:0];
               stk_wd   = bhead[SLOT_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
            scan_in  = bid_t_ff[bk_ff];
            state_in = S_SCANB_R;
         end
         S_SCANB_R: begin
            lvl_ra   = lvl_index(bk_ff, 1'b0, scan_ff);
            state_in = S_SCANB_C;
         end
         // walk the bid side down to the next resting level
         S_SCANB_C: begin
            if (lvl_head != NIL_SLOT) begin
               bid_t_in[bk_ff] = scan_ff;
               state_in = (aq_ff == '0) ? S_POPA : S_M0;
            end else if (scan_ff == '0) begin
               bid_v_in[bk_ff] = 1'b0;
               state_in = (aq_ff == '0) ? S_POPA : S_M0;
            end else begin
               scan_in  = scan_ff - TICK_W'(1);
               state_in = S_SCANB_R;
            end
         end
         S_POPA: begin
            lvl_we = 1'b1;
            lvl_wa = lvl_index(bk_ff, 1'b1, ask_t_ff[bk_ff]);
            lvl_wd = (alink_ff == NIL_SLOT) ? {NIL_SLOT, NIL_SLOT}
                                            : {alink_ff, aent_ff[LINK_W-1:0]};
            if (int'(count_ff) < POOL_SLOTS) begin
               stk_we   = 1'b1;
               stk_wa   = count_ff[SLOT_W-1:0];
               stk_wd   = ahead[SLOT_W-1:0];
               count_in = count_ff + CNT_W'(1);
            end
            scan_in  = ask_t_ff[bk_ff];
            state_in = S_SCANA_R;
         end
         S_SCANA_R: begin
            lvl_ra   = lvl_index(bk_ff, 1'b1, scan_ff);
            state_in = S_SCANA_C;
         end
         // walk the ask side up to the next resting level
         S_SCANA_C: begin
            if (lvl_head != NIL_SLOT) begin
               ask_t_in[bk_ff] = scan_ff;
               state_in = S_M0;
            end else if (scan_ff == TICK_W'(TICK_LEVELS - 1)) begin
               ask_v_in[bk_ff] = 1'b0;
               state_in = S_M0;
            end else begin
               scan_in  = scan_ff + TICK_W'(1);
               state_in = S_SCANA_R;
            end
         end
         S_STATUS: begin
            emit_valid = 1'b1;
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         count_ff <= CNT_W'(POOL_SLOTS);
         fills_ff <= '0;
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            bid_v_ff[i] <= 1'b0;
            ask_v_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
         fills_ff <= fills_in;
         bid_v_ff <= bid_v_in;
         ask_v_ff <= ask_v_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bid_t_ff  <= bid_t_in;
      ask_t_ff  <= ask_t_in;
      ord_ff    <= ord_in;
      bk_ff     <= bk_in;
      slot_ff   <= slot_in;
      bent_ff   <= bent_in;
      aent_ff   <= aent_in;
      bq_ff     <= bq_in;
      aq_ff     <= aq_in;
      bid_id_ff <= bid_id_in;
      blink_ff  <= blink_in;
      alink_ff  <= alink_in;
      scan_ff   <= scan_in;
   end

endmodule

// File: design/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// Top level of the limit order book matcher: request unpacking and result register.
// Depends on lobm_pkg and lobm_engine.
//
// Usage: one limit order per request on the req_ channel; each order yields a
// run of responses on the rsp_ channel: zero or more fills (rsp_tuser = fill,
// rsp_tlast = 0) and then one status or reject response (rsp_tlast = 1) that
// carries the best bid and best ask of the symbol's book.
// Orders are handled one at a time by a sequencer over the level queue memory
// and the slot stores, each with registered reads. The time an accepted order
// takes grows with each fill, with each fill that retires a resting order and
// with each empty level the best-tick scan walks over; responses then pass
// through the output register.
// Reset: synchronous, active high. After reset a clearing pass empties every
// level queue and refills the free slot stack; req_tready stays low meanwhile.
// Stall: a response is held in the output register while rsp_tready is low;
// the sequencer waits at its next response, and the next order is accepted
// while the final response of the previous order is still waiting.
module limit_order_book_matcher
   import lobm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // symbol_index[3:0], order_side[4], limit_tick[20:5], order_quantity[52:21],
   // order_ident[84:53], zero fill [87:85]
   input  logic [87:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fill_symbol[3:0], buyer_ident[35:4], seller_ident[67:36],
   // fill_quantity[99:68], fill_tick[109:100], aggressor[110],
   // top_bid_tick[120:111], top_bid_valid[121], top_ask_tick[131:122],
   // top_ask_valid[132], zero fill [135:133]
   output logic [135:0] rsp_tdata,
   // result_kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   lobm_order_type  order;
   lobm_result_type emit_data;
   logic            emit_valid, out_free;
   logic            rsp_valid_ff, rsp_valid_in;
   lobm_result_type rsp_ff, rsp_in;

   assign order = req_tdata[84:0];

   lobm_engine u_engine (
      .clock(clock), .reset(reset),
      .order_valid(req_tvalid), .order(order), .order_ready(req_tready),
      .out_free(out_free), .emit_valid(emit_valid), .emit_data(emit_data));

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_free) begin
         rsp_valid_in = emit_valid;
         rsp_in       = emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.result_kind;
   assign rsp_tlast  = rsp_ff.run_last;
   assign rsp_tdata  = {3'b000, rsp_ff[$bits(lobm_result_type)-1:3]};

endmodule

// File: design/lobm_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the limit order book matcher, bound to the top level.
// Depends on lobm_pkg.
module lobm_checker
   import lobm_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // fills never close a run, status and rejects always do
   a_fill_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FILL |-> !rsp_tlast)
      else $error("fill marked last");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_FILL |-> rsp_tlast)
      else $error("status response not marked last");

   // fills carry no book tops
   a_fill_tops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FILL |-> !rsp_tdata[121] && !rsp_tdata[132])
      else $error("fill carries top valid bits");

   // the clearing pass blocks requests after reset
   a_clear: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request accepted during clearing pass");

endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (.*);

// File: bench/lobm_checker.sv
`timescale 1ns / 1ps
// Checker for the limit order book matcher: watches both stream channels,
// keeps its own copy of every book and compares each response. Depends on lobm_pkg.
module lobm_scoreboard
   import lobm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [87:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending,
   output int           fills_seen
);

   // book image: queue ends per level, slot stores, free stack, best ticks
   logic [LINK_W-1:0] q_head [LVL_ENTRIES];
   logic [LINK_W-1:0] q_tail [LVL_ENTRIES];
   logic [31:0]       sl_ident [POOL_SLOTS];
   logic [31:0]       sl_qty [POOL_SLOTS];
   logic [LINK_W-1:0] sl_link [POOL_SLOTS];
   logic [SLOT_W-1:0] free_stack [POOL_SLOTS];
   int                free_cnt;
   int                top_bid [SYMBOL_COUNT];
   int                top_ask [SYMBOL_COUNT];

   lobm_result_type   expected_rsp [$];

   function automatic int level_of(int bk, int side, int tick);
      return (bk * 2 + side) * TICK_LEVELS + tick;
   endfunction

   // queue one expected response; tops only on status and reject
   function automatic void push_rsp(logic [1:0] kind, logic last, logic [3:0] sym,
                                    logic [31:0] buyer, logic [31:0] seller,
                                    logic [31:0] qty, int ftick, logic side,
                                    int bk, bit tops);
      lobm_result_type r;
      r = '0;
      r.result_kind   = kind;
      r.run_last      = last;
      r.fill_symbol   = sym;
      r.buyer_ident   = buyer;
      r.seller_ident  = seller;
      r.fill_quantity = qty;
      r.fill_tick     = 10'(ftick);
      r.aggressor     = side;
      if (tops) begin
         if (top_bid[bk] >= 0) begin
            r.top_bid_tick  = 10'(top_bid[bk]);
            r.top_bid_valid = 1'b1;
         end
         if (top_ask[bk] < TICK_LEVELS) begin
            r.top_ask_tick  = 10'(top_ask[bk]);
            r.top_ask_valid = 1'b1;
         end
      end
      expected_rsp.push_back(r);
   endfunction

   // remove the front order of a level and return its slot to the pool
   function automatic void retire_front(int li);
      int h;
      h = q_head[li];
      if (h >= POOL_SLOTS) return;
      if (sl_link[h] == NIL_SLOT) begin
         q_head[li] = NIL_SLOT;
         q_tail[li] = NIL_SLOT;
      end else begin
         q_head[li] = sl_link[h];
      end
      if (free_cnt < POOL_SLOTS) begin
         free_stack[free_cnt] = SLOT_W'(h);
         free_cnt++;
      end
   endfunction

   // handle one order: reject it or rest it, then match while the book is crossed
   function automatic void match_order(lobm_order_type o);
      int bk, tick, s, li, n, bb, ba, bli, ali, bs, as_;
      logic [31:0] tq;
      bk   = int'(o.symbol_index) % SYMBOL_COUNT;
      tick = o.limit_tick;
      n    = 0;
      if (tick >= TICK_LEVELS) begin
         push_rsp(KIND_BAD_TICK, 1, o.symbol_index, 0, 0, 0, 0, o.order_side, bk, 1);
         return;
      end
      if (free_cnt == 0) begin
         push_rsp(KIND_POOL_FULL, 1, o.symbol_index, 0, 0, 0, 0, o.order_side, bk, 1);
         return;
      end
      free_cnt--;
      s = free_stack[free_cnt];
      sl_ident[s] = o.order_ident;
      sl_qty[s]   = o.order_quantity;
      sl_link[s]  = NIL_SLOT;
      li = level_of(bk, o.order_side, tick);
      if (q_head[li] == NIL_SLOT) begin
         q_head[li] = LINK_W'(s);
      end else begin
         sl_link[q_tail[li]] = LINK_W'(s);
      end
      q_tail[li] = LINK_W'(s);
      if (o.order_side == 1'b0) begin
         if (tick > top_bid[bk]) top_bid[bk] = tick;
      end else begin
         if (tick < top_ask[bk]) top_ask[bk] = tick;
      end

      while (n < MAX_FILLS) begin
         bb = top_bid[bk];
         ba = top_ask[bk];
         if (bb < 0 || ba >= TICK_LEVELS || bb < ba) break;
         bli = level_of(bk, 0, bb);
         ali = level_of(bk, 1, ba);
         bs  = q_head[bli];
         as_ = q_head[ali];
         if (bs >= POOL_SLOTS || as_ >= POOL_SLOTS) break;
         tq = (sl_qty[as_] < sl_qty[bs]) ? sl_qty[as_] : sl_qty[bs];
         push_rsp(KIND_FILL, 0, o.symbol_index, sl_ident[bs], sl_ident[as_], tq, ba,
                  o.order_side, bk, 0);
         n++;
         sl_qty[bs]  -= tq;
         sl_qty[as_] -= tq;
         if (sl_qty[bs] == 0) begin
            retire_front(bli);
            while (bb >= 0 && q_head[level_of(bk, 0, bb)] == NIL_SLOT) bb--;
            top_bid[bk] = bb;
         end
         if (sl_qty[as_] == 0) begin
            retire_front(ali);
            while (ba < TICK_LEVELS && q_head[level_of(bk, 1, ba)] == NIL_SLOT) ba++;
            top_ask[bk] = ba;
         end
      end
      push_rsp(KIND_DONE, 1, o.symbol_index, 0, 0, 0, 0, o.order_side, bk, 1);
   endfunction

   assign pending = expected_rsp.size();

   // predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin
      lobm_result_type got, want;
      if (reset) begin
         for (int i = 0; i < LVL_ENTRIES; i++) begin
            q_head[i] = NIL_SLOT;
            q_tail[i] = NIL_SLOT;
         end
         for (int i = 0; i < POOL_SLOTS; i++) free_stack[i] = SLOT_W'(POOL_SLOTS - 1 - i);
         free_cnt = POOL_SLOTS;
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            top_bid[i] = -1;
            top_ask[i] = TICK_LEVELS;
         end
         expected_rsp.delete();
         fail_count <= 0;
         fills_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[132:0], rsp_tlast, rsp_tuser};
            if (got.result_kind == KIND_FILL) fills_seen <= fills_seen + 1;
            if (expected_rsp.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp[0];
               expected_rsp.delete(0);
               if (got !== want) begin
                  if (fail_count < 10) begin
                     $display("response mismatch");
                     $display("  kind exp %0d got %0d, last exp %0d got %0d, sym exp %0d got %0d",
                              want.result_kind, got.result_kind, want.run_last,
                              got.run_last, want.fill_symbol, got.fill_symbol);
                     $display("  buyer exp %h got %h, seller exp %h got %h",
                              want.buyer_ident, got.buyer_ident,
                              want.seller_ident, got.seller_ident);
                     $display("  qty exp %h got %h, tick exp %0d got %0d, aggr exp %0d got %0d",
                              want.fill_quantity, got.fill_quantity, want.fill_tick,
                              got.fill_tick, want.aggressor, got.aggressor);
                     $display("  bid exp %0d/%0d got %0d/%0d, ask exp %0d/%0d got %0d/%0d",
                              want.top_bid_valid, want.top_bid_tick, got.top_bid_valid,
                              got.top_bid_tick, want.top_ask_valid, want.top_ask_tick,
                              got.top_ask_valid, got.top_ask_tick);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) match_order(lobm_order_type'(req_tdata[84:0]));
      end
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for the limit order book matcher: clock, reset, order stimulus
// and verdict. Depends on lobm_pkg, lobm_scoreboard and the matcher itself.
module tb
   import lobm_pkg::*;
();

   localparam int CYCLE_LIMIT = 4000000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count, pending, fills_seen;
   int           orders_sent = 0;
   int           cycles = 0;

   limit_order_book_matcher u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   lobm_scoreboard u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending), .fills_seen(fills_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // random backpressure on the response side, with quiet stretches
   initial begin
      int n;
      forever begin
         @(negedge clock);
         rsp_tready <= 1'b1;
         n = $urandom_range(99) < 15 ? $urandom_range(60, 20) : $urandom_range(8);
         repeat (n) @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // present one order and hold it until accepted
   task automatic send_order(logic [3:0] sym, logic side, logic [15:0] tick,
                             logic [31:0] qty, logic [31:0] ident);
      lobm_order_type o;
      int g;
      g = gap_len();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      o.symbol_index   = sym;
      o.order_side     = side;
      o.limit_tick     = tick;
      o.order_quantity = qty;
      o.order_ident    = ident;
      req_tdata  <= {3'b000, o};
      req_tvalid <= 1'b1;
      // ready is stable between edges, so test it before the accepting edge
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      orders_sent++;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] qty;
      logic [15:0] tick;
      int r, waited;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of tick, quantity and id, crossing, rejects
      send_order(4'd0, 1'b0, 16'd0, 32'd1, 32'h0000_0000);
      send_order(4'd0, 1'b1, 16'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(4'd0, 1'b0, 16'd1023, 32'd5, 32'h1234_5678);
      send_order(4'd0, 1'b1, 16'd0, 32'd3, 32'hA5A5_A5A5);
      send_order(4'd1, 1'b0, 16'd1024, 32'd7, 32'd11);
      send_order(4'd1, 1'b1, 16'hFFFF, 32'd7, 32'd12);
      send_order(4'd2, 1'b0, 16'd500, 32'd0, 32'd21);
      send_order(4'd2, 1'b1, 16'd500, 32'd4, 32'd22);
      send_order(4'd2, 1'b0, 16'd500, 32'd0, 32'd23);
      // multi-level sweep on the last symbol
      send_order(4'd15, 1'b1, 16'd300, 32'd2, 32'd31);
      send_order(4'd15, 1'b1, 16'd302, 32'd2, 32'd32);
      send_order(4'd15, 1'b1, 16'd302, 32'd2, 32'd33);
      send_order(4'd15, 1'b1, 16'd310, 32'd2, 32'd34);
      send_order(4'd15, 1'b0, 16'd305, 32'd9, 32'd35);
      send_order(4'd15, 1'b0, 16'd200, 32'd1, 32'd36);
      send_order(4'd15, 1'b1, 16'd100, 32'd8, 32'd37);

      // random orders in a narrow band so books cross often
      repeat (330) begin
         r = $urandom_range(99);
         if (r < 5) tick = 16'($urandom_range(65535, 1024));
         else if (r < 15) tick = 16'($urandom_range(1023));
         else tick = 16'($urandom_range(115, 100));
         r = $urandom_range(99);
         if (r < 85) qty = $urandom_range(8, 1);
         else if (r < 97) qty = $urandom;
         else qty = 32'd0;
         send_order($urandom_range(99) < 80 ? 4'($urandom_range(3)) : 4'($urandom_range(15)),
                    1'($urandom_range(1)), tick, qty, $urandom);
      end

      // exhaust the slot pool with resting bids, then see rejects
      repeat (72) send_order(4'd9, 1'b0, 16'd0, $urandom_range(8, 1), $urandom);
      send_order(4'd9, 1'b1, 16'd5, 32'd1, $urandom);
      send_order(4'd9, 1'b1, 16'd2000, 32'd1, $urandom);
      req_tvalid <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);

      $display("%0d orders sent, %0d fills checked, incl. rejects and pool exhaustion",
               orders_sent, fills_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/lobm_pkg.sv
design/lobm_ram.sv
design/lobm_engine.sv
design/limit_order_book_matcher.sv
design/lobm_checker.sv
bench/lobm_checker.sv
bench/tb.sv
